>>> rtl/frame_allocator_enhanced_clock_top_defines.svh
// Assertion macros shared by the frame allocator checker
`ifndef FRAME_ALLOCATOR_ENHANCED_CLOCK_TOP_DEFINES_SVH
`define FRAME_ALLOCATOR_ENHANCED_CLOCK_TOP_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent
`define FAC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its antecedent
`define FAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/fac_pkg.sv
// Shared types, constants and helpers of the frame allocator
`timescale 1ns / 1ps
package fac_pkg;

    // Frame table geometry (MAX_FRAMES is a power of two)
    localparam int MAX_FRAMES  = 256;
    localparam int FRAME_W     = $clog2(MAX_FRAMES);
    localparam int CNT_W       = FRAME_W + 1;

    // Free-frame scanner looks at one chunk of occupancy bits per cycle
    localparam int CHUNK_W     = (MAX_FRAMES < 16) ? (MAX_FRAMES / 2) : 8;
    localparam int CHUNK_LW    = $clog2(CHUNK_W);
    localparam int N_CHUNKS    = MAX_FRAMES / CHUNK_W;
    localparam int CHUNK_IDX_W = $clog2(N_CHUNKS);

    localparam logic [CNT_W-1:0] RESET_COUNT = CNT_W'(MAX_FRAMES);

    // Operation codes
    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_MARK   = 2'd2;
    localparam logic [1:0] OP_VICTIM = 2'd3;

    typedef struct packed {
        logic [1:0]         operation;
        logic [FRAME_W-1:0] frame_index;
        logic               used_flag;
        logic               modified_flag;
    } t_cmd;

    typedef struct packed {
        logic [FRAME_W-1:0] result_frame;
        logic               found;
        logic               victim_modified;
        logic               any_free;
    } t_result;

    // Per-frame bits held in the frame RAM
    typedef struct packed {
        logic used;
        logic modified;
    } t_frame_bits;

    // Status handed back by the free-frame scanner
    typedef struct packed {
        logic               done;
        logic               found;
        logic [FRAME_W-1:0] frame;
    } t_scan_res;

    // Clamp the frame count register to 1..MAX_FRAMES
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] fc);
        logic [CNT_W-1:0] n;
        n = fc;
        if (n == '0) begin
            n = CNT_W'(1);
        end else if (n > RESET_COUNT) begin
            n = RESET_COUNT;
        end
        return n;
    endfunction

    // Advance a clock position, wrapping at the active frame count
    function automatic logic [FRAME_W-1:0] next_frame(input logic [FRAME_W-1:0] p,
                                                       input logic [CNT_W-1:0]   n);
        logic [CNT_W-1:0] q;
        q = CNT_W'(p) + CNT_W'(1);
        return (q >= n) ? '0 : q[FRAME_W-1:0];
    endfunction

endpackage

>>> rtl/fac_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module fac_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/fac_scan.sv
// Chunked search for the lowest free frame below the active count
`timescale 1ns / 1ps
module fac_scan
    import fac_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [MAX_FRAMES-1:0] i_occ,
    input  logic [CNT_W-1:0]      i_count,
    output t_scan_res             o_res
);

    logic                   r_active;
    logic                   n_active;
    logic [CHUNK_IDX_W-1:0] r_chunk;
    logic [CHUNK_IDX_W-1:0] n_chunk;
    t_scan_res              r_res;
    t_scan_res              n_res;

    logic [CNT_W-1:0]       base;
    logic [CHUNK_W-1:0]     chunk_occ;
    logic [CHUNK_W-1:0]     chunk_free;
    logic                   hit;
    logic [FRAME_W-1:0]     hit_pos;
    logic                   last;

    // Pick out the current chunk and mark its free frames below the count
    always_comb begin
        base      = CNT_W'(r_chunk) << CHUNK_LW;
        chunk_occ = i_occ[base[FRAME_W-1:0] +: CHUNK_W];
        last      = (base + CNT_W'(CHUNK_W)) >= i_count;
        for (int k = 0; k < CHUNK_W; k++) begin
            chunk_free[k] = !chunk_occ[k] && ((base + CNT_W'(k)) < i_count);
        end
        hit     = |chunk_free;
        hit_pos = '0;
        for (int k = CHUNK_W - 1; k >= 0; k--) begin
            if (chunk_free[k]) begin
                hit_pos = base[FRAME_W-1:0] + FRAME_W'(k);
            end
        end
    end

    // Advance one chunk a cycle, stop at the first free frame or the end
    always_comb begin
        n_active   = r_active;
        n_chunk    = r_chunk;
        n_res      = r_res;
        n_res.done = 1'b0;
        if (i_start) begin
            n_active = 1'b1;
            n_chunk  = '0;
        end else if (r_active) begin
            if (hit) begin
                n_active    = 1'b0;
                n_res.done  = 1'b1;
                n_res.found = 1'b1;
                n_res.frame = hit_pos;
            end else if (last) begin
                n_active    = 1'b0;
                n_res.done  = 1'b1;
                n_res.found = 1'b0;
                n_res.frame = '0;
            end else begin
                n_chunk = r_chunk + CHUNK_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_res    <= '0;
        end else begin
            r_active <= n_active;
            r_res    <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chunk <= n_chunk;
    end

    assign o_res = r_res;

endmodule

>>> rtl/frame_allocator_enhanced_clock_top.sv
// Frame allocator: occupancy bits, frame RAM and enhanced clock sequencer
// Sequencing: free and mark end with an any-free scan of the occupancy chunks;
//   allocate first writes the frame found by a first-free scan, then runs that scan.
// Victim: each occupied frame visited is stepped and then evaluated, an empty one only
//   stepped, over at most four laps of frame_count, plus the any-free scan. One item at a time.
// Reset: occupancy cleared at once, pointer 0, frame_count 256; results are
//   one-cycle strobes that the receiver cannot stall.
`timescale 1ns / 1ps
module frame_allocator_enhanced_clock_top
    import fac_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_cmd             i_cmd,
    output logic             o_result_valid,
    output t_result          o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_ALLOC    = 3'd2;
    localparam logic [2:0] S_MARK_WR  = 3'd3;
    localparam logic [2:0] S_V_STEP   = 3'd4;
    localparam logic [2:0] S_V_EVAL   = 3'd5;
    localparam logic [2:0] S_FINAL    = 3'd6;

    // Control state
    logic [2:0]            r_state,       n_state;
    logic [CNT_W-1:0]      r_frame_count, n_frame_count;
    logic [MAX_FRAMES-1:0] r_occ,         n_occ;
    logic [FRAME_W-1:0]    r_ptr,         n_ptr;
    logic                  r_out_valid,   n_out_valid;

    // Working registers of the current item
    t_cmd                  r_cmd,         n_cmd;
    logic [FRAME_W-1:0]    r_p,           n_p;
    logic [FRAME_W-1:0]    r_start,       n_start;
    logic                  r_pass_b,      n_pass_b;
    logic                  r_seen,        n_seen;
    logic [FRAME_W-1:0]    r_res_frame,   n_res_frame;
    logic                  r_found,       n_found;
    logic                  r_vmod,        n_vmod;
    t_result               r_out,         n_out;

    logic [CNT_W-1:0]      n_frames;
    logic                  idx_ok;
    logic [FRAME_W-1:0]    p_next;
    logic                  take;

    logic                  ram_we;
    logic [FRAME_W-1:0]    ram_waddr;
    t_frame_bits           ram_wdata;
    logic [FRAME_W-1:0]    ram_raddr;
    t_frame_bits           ram_rdata;

    logic                  scan_start;
    t_scan_res             scan_res;

    fac_ram #(
        .WIDTH ($bits(t_frame_bits)),
        .DEPTH (MAX_FRAMES)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    fac_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scan_start),
        .i_occ   (r_occ),
        .i_count (n_frames),
        .o_res   (scan_res)
    );

    // Decode the shared terms of the current item
    always_comb begin
        n_frames  = eff_count(r_frame_count);
        idx_ok    = (CNT_W'(r_cmd.frame_index) < n_frames) && r_occ[r_cmd.frame_index];
        p_next    = next_frame(r_p, n_frames);
        take      = r_pass_b ? (!ram_rdata.used && ram_rdata.modified)
                             : (!ram_rdata.used && !ram_rdata.modified);
        ram_raddr = (r_state == S_DISPATCH) ? r_cmd.frame_index : r_p;
    end

    // Sequence allocate, free, mark and the victim walk
    always_comb begin
        n_state       = r_state;
        n_frame_count = r_frame_count;
        n_occ         = r_occ;
        n_ptr         = r_ptr;
        n_out_valid   = 1'b0;
        n_cmd         = r_cmd;
        n_p           = r_p;
        n_start       = r_start;
        n_pass_b      = r_pass_b;
        n_seen        = r_seen;
        n_res_frame   = r_res_frame;
        n_found       = r_found;
        n_vmod        = r_vmod;
        n_out         = r_out;
        ram_we        = 1'b0;
        ram_waddr     = r_p;
        ram_wdata     = ram_rdata;
        scan_start    = 1'b0;

        if (i_cfg_valid && o_cfg_ready) begin
            n_frame_count = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd       = i_cmd;
                    n_res_frame = '0;
                    n_found     = 1'b0;
                    n_vmod      = 1'b0;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (r_cmd.operation)
                    OP_ALLOC: begin
                        scan_start = 1'b1;
                        n_state    = S_ALLOC;
                    end
                    OP_FREE: begin
                        if (idx_ok) begin
                            n_occ[r_cmd.frame_index] = 1'b0;
                        end
                        scan_start = 1'b1;
                        n_state    = S_FINAL;
                    end
                    OP_MARK: begin
                        if (idx_ok) begin
                            n_state = S_MARK_WR;
                        end else begin
                            scan_start = 1'b1;
                            n_state    = S_FINAL;
                        end
                    end
                    OP_VICTIM: begin
                        // Restart at frame 0 when the pointer lies at or beyond the count
                        if (CNT_W'(r_ptr) >= n_frames) begin
                            n_p     = '0;
                            n_start = '0;
                        end else begin
                            n_p     = r_ptr;
                            n_start = r_ptr;
                        end
                        n_pass_b = 1'b0;
                        n_seen   = 1'b0;
                        n_state  = S_V_STEP;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_ALLOC: begin
                if (scan_res.done) begin
                    if (scan_res.found) begin
                        n_occ[scan_res.frame] = 1'b1;
                        ram_we             = 1'b1;
                        ram_waddr          = scan_res.frame;
                        ram_wdata.used     = r_cmd.used_flag;
                        ram_wdata.modified = r_cmd.modified_flag;
                        n_res_frame        = scan_res.frame;
                        n_found            = 1'b1;
                    end
                    scan_start = 1'b1;
                    n_state    = S_FINAL;
                end
            end
            S_MARK_WR: begin
                // OR the new bits into the entry read last cycle
                ram_we             = 1'b1;
                ram_waddr          = r_cmd.frame_index;
                ram_wdata.used     = ram_rdata.used | r_cmd.used_flag;
                ram_wdata.modified = ram_rdata.modified | r_cmd.modified_flag;
                scan_start         = 1'b1;
                n_state            = S_FINAL;
            end
            S_V_STEP: begin
                if (r_occ[r_p]) begin
                    n_seen  = 1'b1;
                    n_state = S_V_EVAL;
                end else begin
                    // Skip an empty frame; a full lap with nothing occupied ends the walk
                    n_p = p_next;
                    if (p_next == r_start) begin
                        if (!r_seen) begin
                            n_ptr      = r_start;
                            scan_start = 1'b1;
                            n_state    = S_FINAL;
                        end else begin
                            n_pass_b = !r_pass_b;
                        end
                    end
                end
            end
            S_V_EVAL: begin
                if (take) begin
                    n_res_frame   = r_p;
                    n_found       = 1'b1;
                    n_vmod        = ram_rdata.modified;
                    n_occ[r_p]    = 1'b0;
                    n_ptr         = p_next;
                    scan_start    = 1'b1;
                    n_state       = S_FINAL;
                end else begin
                    // Second-chance pass drops the used bit of every occupied frame it passes over
                    if (r_pass_b) begin
                        ram_we         = 1'b1;
                        ram_waddr      = r_p;
                        ram_wdata.used = 1'b0;
                    end
                    n_p = p_next;
                    if (p_next == r_start) begin
                        n_pass_b = !r_pass_b;
                    end
                    n_state = S_V_STEP;
                end
            end
            S_FINAL: begin
                if (scan_res.done) begin
                    n_out_valid           = 1'b1;
                    n_out.result_frame    = r_res_frame;
                    n_out.found           = r_found;
                    n_out.victim_modified = r_vmod;
                    n_out.any_free        = scan_res.found;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_frame_count <= RESET_COUNT;
            r_occ         <= '0;
            r_ptr         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_frame_count <= n_frame_count;
            r_occ         <= n_occ;
            r_ptr         <= n_ptr;
            r_out_valid   <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_p         <= n_p;
        r_start     <= n_start;
        r_pass_b    <= n_pass_b;
        r_seen      <= n_seen;
        r_res_frame <= n_res_frame;
        r_found     <= n_found;
        r_vmod      <= n_vmod;
        r_out       <= n_out;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_cfg_ready    = (r_state == S_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

>>> rtl/fac_checker.sv
// Port-level checks of the frame allocator, bound to the top level
`timescale 1ns / 1ps
`include "frame_allocator_enhanced_clock_top_defines.svh"
module fac_checker
    import fac_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_result_valid,
    input t_result o_result,
    input logic    i_cfg_valid,
    input logic    o_cfg_ready
);

    // A result strobe lasts one cycle: another result needs a new command first
    `FAC_ASSERT_NEXT(a_strobe_single, o_result_valid, !o_result_valid, "result strobe held")

    // An accepted command makes the block busy
    `FAC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted command not busy")

    // A miss reports frame zero and no write-back
    `FAC_ASSERT_NOW(a_miss_zero, o_result_valid && !o_result.found, o_result.result_frame == '0 && !o_result.victim_modified, "miss with nonzero fields")

    // Configuration transfers only while idle
    `FAC_ASSERT_NOW(a_cfg_idle, i_cfg_valid && o_cfg_ready, !busy, "config transfer while busy")

endmodule

bind frame_allocator_enhanced_clock_top fac_checker u_fac_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_result       (o_result),
    .i_cfg_valid    (i_cfg_valid),
    .o_cfg_ready    (o_cfg_ready)
);
